>>> design/msc_pkg.sv
// Shared types and constants of the MSI snooping cache controller.
// Used by the channel interfaces, the controller, the datapath and the top level.
package msc_pkg;

   localparam int ADDR_W = 32;
   localparam int CFG_W = 4;
   localparam int MODE_W = 2;
   localparam int BUSCMD_W = 3;
   localparam int LSTATE_W = 2;
   localparam int LINE_VAL_W = 15;

   localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd3;

   localparam logic [MODE_W-1:0] MODE_CPU = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SNOOP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DATA = 2'd2;

   localparam logic [BUSCMD_W-1:0] BUS_REQ_SH = 3'd0;
   localparam logic [BUSCMD_W-1:0] BUS_REQ_EX = 3'd1;
   localparam logic [BUSCMD_W-1:0] BUS_REPLY = 3'd2;
   localparam logic [BUSCMD_W-1:0] BUS_WRMEM = 3'd3;
   localparam logic [BUSCMD_W-1:0] BUS_INV = 3'd4;

   localparam logic [BUSCMD_W-1:0] ISSUE_NONE = 3'd0;
   localparam logic [BUSCMD_W-1:0] ISSUE_REQ_SH = 3'd1;
   localparam logic [BUSCMD_W-1:0] ISSUE_REQ_EX = 3'd2;
   localparam logic [BUSCMD_W-1:0] ISSUE_WRMEM = 3'd3;
   localparam logic [BUSCMD_W-1:0] ISSUE_INV = 3'd4;

   localparam logic [LSTATE_W-1:0] LINE_I = 2'd0;
   localparam logic [LSTATE_W-1:0] LINE_S = 2'd1;
   localparam logic [LSTATE_W-1:0] LINE_M = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOOKUP
   } msc_state_type;

   typedef struct packed {
      logic clear_en;
      logic load_req;
      logic commit;
   } msc_cmd_type;

   typedef struct packed {
      logic clear_last;
   } msc_status_type;

endpackage

>>> design/msc_req_if.sv
// Request channel of the cache controller: valid, ready and the request fields.
// Depends on msc_pkg.
interface msc_req_if;
   import msc_pkg::*;

   logic valid;
   logic ready;
   logic [MODE_W-1:0] mode;
   logic op;
   logic [ADDR_W-1:0] address;
   logic [BUSCMD_W-1:0] bus_cmd;
   logic granted;

   modport source (output valid, mode, op, address, bus_cmd, granted, input ready);
   modport sink (input valid, mode, op, address, bus_cmd, granted, output ready);
endinterface

>>> design/msc_rsp_if.sv
// Response channel of the cache controller: valid, ready and the response fields.
// Depends on msc_pkg.
interface msc_rsp_if;
   import msc_pkg::*;

   logic valid;
   logic ready;
   logic wants_bus;
   logic urgent;
   logic [BUSCMD_W-1:0] issued_cmd;
   logic [ADDR_W-1:0] issued_address;
   logic access_done;
   logic was_hit;
   logic was_miss;

   modport source (output valid, wants_bus, urgent, issued_cmd, issued_address,
                   access_done, was_hit, was_miss, input ready);
   modport sink (input valid, wants_bus, urgent, issued_cmd, issued_address,
                 access_done, was_hit, was_miss, output ready);
endinterface

>>> design/msc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module msc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/msc_ctrl.sv
// Sequencing state machine of the cache controller: clear pass, request intake,
// tag lookup and response hand-off. Depends on msc_pkg.
module msc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output msc_pkg::msc_cmd_type cmd,
   input  msc_pkg::msc_status_type status
);
   import msc_pkg::*;

   msc_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

>>> design/msc_dpath.sv
// Datapath of the cache controller: request registers, line index arithmetic,
// tag and state RAM, MSI decision logic and response registers.
// Depends on msc_pkg and msc_ram.
module msc_dpath #(
   parameter int MAX_LINES = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [msc_pkg::CFG_W-1:0] csr_wdata,
   input  logic [msc_pkg::MODE_W-1:0] req_mode,
   input  logic req_op,
   input  logic [msc_pkg::ADDR_W-1:0] req_address,
   input  logic [msc_pkg::BUSCMD_W-1:0] req_bus_cmd,
   input  logic req_granted,
   input  msc_pkg::msc_cmd_type cmd,
   output msc_pkg::msc_status_type status,
   output logic rsp_wants_bus,
   output logic rsp_urgent,
   output logic [msc_pkg::BUSCMD_W-1:0] rsp_issued_cmd,
   output logic [msc_pkg::ADDR_W-1:0] rsp_issued_address,
   output logic rsp_access_done,
   output logic rsp_was_hit,
   output logic rsp_was_miss
);
   import msc_pkg::*;

   localparam int IW = MAX_LINES > 1 ? $clog2(MAX_LINES) : 1;
   localparam int MW = $clog2(MAX_LINES + 1);
   localparam int VW = LINE_VAL_W;
   localparam int PW = VW + 33;
   localparam int QMW = VW + MW;
   localparam int EW = ADDR_W + LSTATE_W;
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MAX_LINES);

   logic [CFG_W-1:0] idx_bits_ff;
   logic [MODE_W-1:0] mode_ff;
   logic op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [BUSCMD_W-1:0] bus_cmd_ff;
   logic granted_ff;
   logic [VW-1:0] val_ff, val_in;
   logic [VW-1:0] quot_ff, quot_in;
   logic [PW-1:0] recip_prod;
   logic [QMW-1:0] quot_mul;
   logic [VW-1:0] rem_raw, rem_fix;
   logic [IW-1:0] line_idx;
   logic [IW-1:0] clr_ff, clr_in;
   logic fill_ff, fill_in;
   logic pw_ff, pw_in;
   logic held_ff, held_in;

   logic [EW-1:0] rd_entry;
   logic [ADDR_W-1:0] tag_rd;
   logic [LSTATE_W-1:0] st_rd;
   logic tag_match;
   logic line_we;
   logic [ADDR_W-1:0] new_tag;
   logic [LSTATE_W-1:0] new_st;
   logic ram_we;
   logic [IW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;

   logic wants_in, urgent_in, done_in, hit_in, miss_in;
   logic [BUSCMD_W-1:0] icmd_in;
   logic [ADDR_W-1:0] iaddr_in;
   logic wants_ff, urgent_ff, done_ff, hit_ff, miss_ff;
   logic [BUSCMD_W-1:0] icmd_ff;
   logic [ADDR_W-1:0] iaddr_ff;

   // Line value is the word address masked to index_bits; its remainder modulo
   // MAX_LINES comes from a reciprocal quotient estimate and one correction.
   always_comb begin
      val_in = req_address[VW+1:2] & ~({VW{1'b1}} << idx_bits_ff);
      recip_prod = PW'(val_in) * PW'(RECIP);
      quot_in = recip_prod[32+VW-1:32];
      quot_mul = QMW'(quot_ff) * QMW'(MAX_LINES);
      rem_raw = val_ff - quot_mul[VW-1:0];
      rem_fix = (32'(rem_raw) >= 32'(MAX_LINES)) ? rem_raw - VW'(MAX_LINES) : rem_raw;
      line_idx = IW'(rem_fix);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_bits_ff <= INDEX_BITS_RESET;
         clr_ff <= '0;
         fill_ff <= 1'b0;
         pw_ff <= 1'b0;
         held_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            idx_bits_ff <= csr_wdata;
         end
         clr_ff <= clr_in;
         if (cmd.commit) begin
            fill_ff <= fill_in;
            pw_ff <= pw_in;
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_mode;
         op_ff <= req_op;
         addr_ff <= req_address;
         bus_cmd_ff <= req_bus_cmd;
         granted_ff <= req_granted;
         val_ff <= val_in;
         quot_ff <= quot_in;
      end
      if (cmd.commit) begin
         wants_ff <= wants_in;
         urgent_ff <= urgent_in;
         icmd_ff <= icmd_in;
         iaddr_ff <= iaddr_in;
         done_ff <= done_in;
         hit_ff <= hit_in;
         miss_ff <= miss_in;
      end
   end

   assign clr_in = (cmd.clear_en && !status.clear_last) ? clr_ff + IW'(1) : clr_ff;
   assign status.clear_last = (clr_ff == IW'(MAX_LINES - 1));

   assign ram_we = cmd.clear_en || (cmd.commit && line_we);
   assign ram_waddr = cmd.clear_en ? clr_ff : line_idx;
   assign ram_wdata = cmd.clear_en ? '0 : {new_tag, new_st};

   msc_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_LINES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (line_idx),
      .rd_data (rd_entry)
   );

   assign tag_rd = rd_entry[EW-1:LSTATE_W];
   assign st_rd = rd_entry[LSTATE_W-1:0];
   assign tag_match = (tag_rd == addr_ff);

   always_comb begin
      wants_in = 1'b0;
      urgent_in = 1'b0;
      icmd_in = ISSUE_NONE;
      iaddr_in = '0;
      done_in = 1'b0;
      hit_in = 1'b0;
      miss_in = 1'b0;
      line_we = 1'b0;
      new_tag = tag_rd;
      new_st = st_rd;
      fill_in = fill_ff;
      pw_in = pw_ff;
      held_in = held_ff;
      case (mode_ff)
         MODE_CPU: begin
            wants_in = 1'b1;
            if (st_rd != LINE_I && tag_match) begin
               if (st_rd == LINE_S && op_ff) begin
                  if (granted_ff) begin
                     icmd_in = ISSUE_INV;
                     iaddr_in = addr_ff;
                     done_in = 1'b1;
                     hit_in = 1'b1;
                     held_in = 1'b1;
                     line_we = 1'b1;
                     new_st = LINE_M;
                  end
               end else begin
                  wants_in = 1'b0;
                  done_in = 1'b1;
                  hit_in = 1'b1;
               end
            end else if (st_rd == LINE_M) begin
               if (granted_ff) begin
                  icmd_in = ISSUE_WRMEM;
                  iaddr_in = tag_rd;
                  held_in = 1'b1;
                  line_we = 1'b1;
                  new_st = LINE_I;
                  new_tag = '0;
               end
            end else if (granted_ff) begin
               icmd_in = op_ff ? ISSUE_REQ_EX : ISSUE_REQ_SH;
               iaddr_in = addr_ff;
               done_in = 1'b1;
               miss_in = 1'b1;
               held_in = 1'b1;
               fill_in = 1'b1;
               pw_in = op_ff;
            end
         end
         MODE_SNOOP: begin
            if (bus_cmd_ff == BUS_REQ_SH || bus_cmd_ff == BUS_REQ_EX) begin
               if (st_rd == LINE_M && tag_match) begin
                  line_we = 1'b1;
                  if (bus_cmd_ff == BUS_REQ_EX) begin
                     new_st = LINE_I;
                     new_tag = '0;
                  end else begin
                     new_st = LINE_S;
                  end
                  wants_in = 1'b1;
                  urgent_in = 1'b1;
                  if (granted_ff) begin
                     icmd_in = ISSUE_WRMEM;
                     iaddr_in = addr_ff;
                  end
               end else if (st_rd == LINE_S && tag_match && bus_cmd_ff == BUS_REQ_EX) begin
                  line_we = 1'b1;
                  new_st = LINE_I;
                  new_tag = '0;
               end
            end else if (bus_cmd_ff == BUS_INV) begin
               if (st_rd != LINE_I && tag_match && !held_ff) begin
                  line_we = 1'b1;
                  new_st = LINE_I;
                  new_tag = '0;
               end
            end
         end
         MODE_DATA: begin
            if ((bus_cmd_ff == BUS_REPLY || bus_cmd_ff == BUS_WRMEM) && fill_ff) begin
               fill_in = 1'b0;
               line_we = 1'b1;
               new_tag = addr_ff;
               new_st = pw_ff ? LINE_M : LINE_S;
            end
            held_in = 1'b0;
         end
         default: begin
            held_in = held_ff;
         end
      endcase
   end

   assign rsp_wants_bus = wants_ff;
   assign rsp_urgent = urgent_ff;
   assign rsp_issued_cmd = icmd_ff;
   assign rsp_issued_address = iaddr_ff;
   assign rsp_access_done = done_ff;
   assign rsp_was_hit = hit_ff;
   assign rsp_was_miss = miss_ff;
endmodule

>>> design/msi_snooping_cache_controller.sv
// Direct-mapped MSI snooping cache controller for one processor, top level.
// Depends on msc_pkg, msc_req_if, msc_rsp_if, msc_ctrl, msc_dpath and msc_ram.
//
// Each request is one bus phase: a processor access, a snooped bus command or a
// data return, and it yields exactly one response. The accepting edge captures the
// request and the line index quotient in ST_IDLE, the tag and state RAM is read in
// ST_READ, and in ST_LOOKUP the line is decided and written back and the response
// register loaded. No new request is taken until the last one has left ST_LOOKUP.
// A response left waiting lets one more request in, which then holds at its
// lookup until the waiting response is taken. After reset the controller clears
// every entry of the line RAM, during which no request is taken; writes to
// index_bits through csr_we and csr_wdata are taken at any time and must only be
// made while no request is in flight.
module msi_snooping_cache_controller #(
   parameter int MAX_LINES = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [msc_pkg::CFG_W-1:0] csr_wdata,
   msc_req_if.sink req_ch,
   msc_rsp_if.source rsp_ch
);
   import msc_pkg::*;

   msc_cmd_type cmd;
   msc_status_type status;

   msc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   msc_dpath #(
      .MAX_LINES (MAX_LINES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_mode           (req_ch.mode),
      .req_op             (req_ch.op),
      .req_address        (req_ch.address),
      .req_bus_cmd        (req_ch.bus_cmd),
      .req_granted        (req_ch.granted),
      .cmd                (cmd),
      .status             (status),
      .rsp_wants_bus      (rsp_ch.wants_bus),
      .rsp_urgent         (rsp_ch.urgent),
      .rsp_issued_cmd     (rsp_ch.issued_cmd),
      .rsp_issued_address (rsp_ch.issued_address),
      .rsp_access_done    (rsp_ch.access_done),
      .rsp_was_hit        (rsp_ch.was_hit),
      .rsp_was_miss       (rsp_ch.was_miss)
   );

`ifndef SYNTH
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("Request accepted while another was in flight.");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> !req_ch.ready && !cmd.commit)
      else $error("Request activity during the RAM clear pass.");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_ch.valid)
      else $error("Committed lookup did not raise the response.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> cmd.clear_en)
      else $error("Reset did not start the RAM clear pass.");
`endif
endmodule
